@@ rtl/sli_pkg.sv @@
`default_nettype none

package sli_pkg;

  localparam int unsigned ValueBits  = 32;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CountBits  = 7;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

  typedef enum logic [StatusBits-1:0] {
    STS_INSERTED  = 2'd0,
    STS_FULL      = 2'd1,
    STS_FOUND     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    action_t                      action;
    logic signed [ValueBits-1:0]  value;
  } req_beat_t;

  typedef struct packed {
    status_t                      status;
    logic        [CountBits-1:0]  entry_count;
  } rsp_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/sorted_list_insert_search.sv @@
`default_nettype none

// Channel | Dir | Handshake            | Payload
// req     | in  | req_valid/req_ready  | sli_pkg::req_beat_t (action, value)
// rsp     | out | rsp_valid/rsp_ready  | sli_pkg::rsp_beat_t (status, entry_count)
//
// One beat at a time; req_ready is high only in the idle cycle. The store has one
// write and one read port with registered read data; each entry is read in STEP
// and compared in CMP. An insert walks down from the tail, moving each entry not
// smaller than its value up a slot, then writes it; a search walks up from the
// head to a match or the end. A full-store insert goes straight to the result.
// rsp holds until rsp_ready, then idle. Reset clears the count, not the store.

module sorted_list_insert_search #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire sli_pkg::req_beat_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output sli_pkg::rsp_beat_t      rsp
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] rd_data;
  logic        [AW-1:0]          rd_addr;

  sli_pkg::state_t  state, state_next;
  sli_pkg::action_t action, action_next;
  sli_pkg::status_t status, status_next;
  logic signed [VALUE_WIDTH-1:0] val, val_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] count, count_next;

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic signed [VALUE_WIDTH-1:0] wdata;

  logic req_fire, is_insert, pos_zero, pos_at_end, not_smaller, equal;
  logic signed [VALUE_WIDTH-1:0] req_val;

  assign req_fire   = req_valid && req_ready;
  assign req_val    = VALUE_WIDTH'(req.value);
  assign is_insert  = (action == sli_pkg::ACT_INSERT);
  assign pos_zero   = (pos == '0);
  assign pos_at_end = (pos == count);
  // one entry compared per probe (ordering for insert, equality for search)
  assign not_smaller = !(rd_data < val);
  assign equal       = (rd_data == val);
  // insert walks down from the tail, search walks up from the head
  assign rd_addr = is_insert ? AW'(pos - CW'(1)) : pos[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      sli_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (req.action == sli_pkg::ACT_INSERT && count == FULL_COUNT) begin
            state_next = sli_pkg::ST_DONE;
          end else begin
            state_next = sli_pkg::ST_STEP;
          end
        end
      end
      sli_pkg::ST_STEP: begin
        if (is_insert ? pos_zero : pos_at_end) begin
          state_next = sli_pkg::ST_DONE;
        end else begin
          state_next = sli_pkg::ST_CMP;
        end
      end
      sli_pkg::ST_CMP: begin
        if (is_insert ? !not_smaller : equal) begin
          state_next = sli_pkg::ST_DONE;
        end else begin
          state_next = sli_pkg::ST_STEP;
        end
      end
      sli_pkg::ST_DONE: begin
        if (rsp_ready) begin
          state_next = sli_pkg::ST_IDLE;
        end
      end
      default: state_next = sli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    action_next = action;
    val_next    = val;
    pos_next    = pos;
    count_next  = count;
    status_next = status;
    we          = 1'b0;
    waddr       = pos[AW-1:0];
    wdata       = val;
    case (state)
      sli_pkg::ST_IDLE: begin
        if (req_fire) begin
          action_next = req.action;
          val_next    = req_val;
          pos_next    = (req.action == sli_pkg::ACT_INSERT) ? count : '0;
          status_next = sli_pkg::STS_FULL;
        end
      end
      sli_pkg::ST_STEP: begin
        if (is_insert && pos_zero) begin
          we          = 1'b1;
          count_next  = count + CW'(1);
          status_next = sli_pkg::STS_INSERTED;
        end else if (!is_insert && pos_at_end) begin
          status_next = sli_pkg::STS_NOT_FOUND;
        end
      end
      sli_pkg::ST_CMP: begin
        if (is_insert) begin
          we = 1'b1;
          if (not_smaller) begin
            wdata    = rd_data;
            pos_next = pos - CW'(1);
          end else begin
            count_next  = count + CW'(1);
            status_next = sli_pkg::STS_INSERTED;
          end
        end else if (equal) begin
          status_next = sli_pkg::STS_FOUND;
        end else begin
          pos_next = pos + CW'(1);
        end
      end
      sli_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sli_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    action <= action_next;
    val    <= val_next;
    pos    <= pos_next;
    status <= status_next;
  end

  assign req_ready       = (state == sli_pkg::ST_IDLE);
  assign rsp_valid       = (state == sli_pkg::ST_DONE);
  assign rsp.status      = status;
  assign rsp.entry_count = sli_pkg::CountBits'(count);

endmodule

`default_nettype wire
